FILE: hdl/csvp_pkg.sv
package csvp_pkg;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_SPACE  = 2'd1,
        PH_NUMBER = 2'd2,
        PH_SKIP   = 2'd3
    } phase_t;

    localparam logic KIND_CELL    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_VT      = 8'h0B;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic               item_kind;
        logic [5:0]         cell_row;
        logic [5:0]         cell_column;
        logic signed [31:0] cell_value;
        logic [6:0]         rows_found;
        logic [12:0]        cols_found;
        logic               parse_error;
        logic               end_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    item0;
        result_t    item1;
    } push_t;

endpackage

FILE: hdl/csvp_if.sv
interface csvp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

interface csvp_out_if;
    logic               valid;
    logic               ready;
    logic               item_kind;
    logic [5:0]         cell_row;
    logic [5:0]         cell_column;
    logic signed [31:0] cell_value;
    logic [6:0]         rows_found;
    logic [12:0]        cols_found;
    logic               parse_error;
    logic               end_of_run;

    modport source (output valid, output item_kind, output cell_row, output cell_column,
                    output cell_value, output rows_found, output cols_found,
                    output parse_error, output end_of_run, input ready);
    modport sink (input valid, input item_kind, input cell_row, input cell_column,
                  input cell_value, input rows_found, input cols_found,
                  input parse_error, input end_of_run, output ready);
endinterface

FILE: hdl/csvp_parser.sv
module csvp_parser #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    csvp_in_if.sink           text,
    input  logic              room,
    output csvp_pkg::push_t   push
);

    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    csvp_pkg::phase_t phase_reg, phase_next;
    logic [31:0]      acc_reg, acc_next;
    logic             neg_reg, neg_next;
    logic             seen_reg, seen_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] rcnt_reg, rcnt_next;
    logic [12:0]      ccnt_reg, ccnt_next;
    logic             wfix_reg, wfix_next;
    logic             rcounted_reg, rcounted_next;
    logic             halt_reg, halt_next;
    logic             err_reg, err_next;

    logic        accept;
    logic        is_space, is_sign, is_digit, is_sep;
    logic [35:0] acc_sum;
    logic [31:0] acc_sat;
    logic [31:0] cell_mag;
    logic [31:0] cell_val;
    logic        stop;
    logic [1:0]  nres;
    csvp_pkg::result_t cell_item, sum_item, item0, item1;

    assign accept = text.valid && text.ready;
    assign text.ready = room;

    assign is_space = (text.text_byte == csvp_pkg::CH_SPACE) || (text.text_byte == csvp_pkg::CH_TAB)
                   || (text.text_byte == csvp_pkg::CH_CR) || (text.text_byte == csvp_pkg::CH_VT)
                   || (text.text_byte == csvp_pkg::CH_FF);
    assign is_sign  = (text.text_byte == csvp_pkg::CH_PLUS) || (text.text_byte == csvp_pkg::CH_MINUS);
    assign is_digit = (text.text_byte >= csvp_pkg::CH_ZERO) && (text.text_byte <= csvp_pkg::CH_NINE);
    assign is_sep   = (text.text_byte == csvp_pkg::CH_COMMA)
                   || (text.text_byte == csvp_pkg::CH_NEWLINE)
                   || (text.text_byte == csvp_pkg::CH_NUL);

    assign acc_sum = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                   + {32'b0, 4'(text.text_byte - csvp_pkg::CH_ZERO)};
    assign acc_sat = (acc_sum > {4'b0, csvp_pkg::MAG_LIMIT}) ? csvp_pkg::MAG_LIMIT
                                                              : acc_sum[31:0];

    // A cell leaves either on a non-digit that closes the number or on a final digit,
    // so the magnitude is the stored one or the one that the digit just extended.
    always_comb
    begin
        cell_mag = is_digit ? acc_sat : acc_reg;
        if (neg_reg)
        begin
            cell_val = 32'd0 - cell_mag;
        end
        else if (cell_mag > csvp_pkg::POS_MAX)
        begin
            cell_val = csvp_pkg::POS_MAX;
        end
        else
        begin
            cell_val = cell_mag;
        end
        cell_item             = '0;
        cell_item.item_kind   = csvp_pkg::KIND_CELL;
        cell_item.cell_row    = 6'(row_reg);
        cell_item.cell_column = 6'(col_reg);
        cell_item.cell_value  = cell_val;
    end

    always_comb
    begin
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        neg_next      = neg_reg;
        seen_next     = seen_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        rcnt_next     = rcnt_reg;
        ccnt_next     = ccnt_reg;
        wfix_next     = wfix_reg;
        rcounted_next = rcounted_reg;
        halt_next     = halt_reg;
        err_next      = err_reg;
        stop          = 1'b0;
        nres          = 2'd0;
        item0         = '0;
        item1         = '0;
        sum_item      = '0;

        if (!halt_reg)
        begin
            if (phase_reg == csvp_pkg::PH_START)
            begin
                if (row_reg >= ROW_W'(MAX_ROWS))
                begin
                    stop = 1'b1;
                end
                else
                begin
                    if (!wfix_reg)
                    begin
                        ccnt_next = ccnt_reg + 13'd1;
                    end
                    if (!rcounted_reg)
                    begin
                        rcnt_next     = rcnt_reg + ROW_W'(1);
                        rcounted_next = 1'b1;
                    end
                    phase_next = csvp_pkg::PH_SPACE;
                end
            end

            if (!stop && phase_next == csvp_pkg::PH_SPACE)
            begin
                if (is_space)
                begin
                    stop = 1'b1;
                end
                else if (is_sign)
                begin
                    neg_next   = (text.text_byte == csvp_pkg::CH_MINUS);
                    phase_next = csvp_pkg::PH_NUMBER;
                    stop       = 1'b1;
                end
                else if (is_digit)
                begin
                    phase_next = csvp_pkg::PH_NUMBER;
                end
                else
                begin
                    err_next  = 1'b1;
                    halt_next = 1'b1;
                    stop      = 1'b1;
                end
            end

            if (!stop && phase_next == csvp_pkg::PH_NUMBER)
            begin
                if (is_digit)
                begin
                    acc_next  = acc_sat;
                    seen_next = 1'b1;
                    stop      = 1'b1;
                end
                else if (!seen_reg)
                begin
                    err_next  = 1'b1;
                    halt_next = 1'b1;
                    stop      = 1'b1;
                end
                else
                begin
                    item0      = cell_item;
                    nres       = 2'd1;
                    phase_next = csvp_pkg::PH_SKIP;
                end
            end

            if (!stop && is_sep)
            begin
                if (text.text_byte == csvp_pkg::CH_NEWLINE)
                begin
                    col_next      = '0;
                    row_next      = row_reg + ROW_W'(1);
                    wfix_next     = 1'b1;
                    rcounted_next = 1'b0;
                end
                else if (col_reg == COL_W'(MAX_COLS - 1))
                begin
                    col_next = '0;
                    row_next = row_reg + ROW_W'(1);
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
                phase_next = csvp_pkg::PH_START;
                acc_next   = '0;
                neg_next   = 1'b0;
                seen_next  = 1'b0;
            end
        end

        if (text.final_byte)
        begin
            if (!halt_next)
            begin
                if (phase_next == csvp_pkg::PH_NUMBER && seen_next)
                begin
                    item0 = cell_item;
                    nres  = 2'd1;
                end
                else if (phase_next == csvp_pkg::PH_SPACE || phase_next == csvp_pkg::PH_NUMBER)
                begin
                    err_next = 1'b1;
                end
            end
            sum_item.item_kind   = csvp_pkg::KIND_SUMMARY;
            sum_item.rows_found  = 7'(rcnt_next);
            sum_item.cols_found  = ccnt_next;
            sum_item.parse_error = err_next;
            sum_item.end_of_run  = 1'b1;
            if (nres == 2'd1)
            begin
                item1 = sum_item;
                nres  = 2'd2;
            end
            else
            begin
                item0 = sum_item;
                nres  = 2'd1;
            end
            phase_next    = csvp_pkg::PH_START;
            acc_next      = '0;
            neg_next      = 1'b0;
            seen_next     = 1'b0;
            row_next      = '0;
            col_next      = '0;
            rcnt_next     = '0;
            ccnt_next     = '0;
            wfix_next     = 1'b0;
            rcounted_next = 1'b0;
            halt_next     = 1'b0;
            err_next      = 1'b0;
        end
        else if (nres == 2'd1)
        begin
            item0.end_of_run = 1'b1;
        end
    end

    // The cell item for the final byte uses the row and column before the byte moved them,
    // which is also what the non-final path needs, since a separator follows the emit.
    always_comb
    begin
        push.count = accept ? nres : 2'd0;
        push.item0 = item0;
        push.item1 = item1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= csvp_pkg::PH_START;
            acc_reg      <= '0;
            neg_reg      <= 1'b0;
            seen_reg     <= 1'b0;
            row_reg      <= '0;
            col_reg      <= '0;
            rcnt_reg     <= '0;
            ccnt_reg     <= '0;
            wfix_reg     <= 1'b0;
            rcounted_reg <= 1'b0;
            halt_reg     <= 1'b0;
            err_reg      <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            acc_reg      <= acc_next;
            neg_reg      <= neg_next;
            seen_reg     <= seen_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            rcnt_reg     <= rcnt_next;
            ccnt_reg     <= ccnt_next;
            wfix_reg     <= wfix_next;
            rcounted_reg <= rcounted_next;
            halt_reg     <= halt_next;
            err_reg      <= err_next;
        end
    end

endmodule

FILE: hdl/csvp_out_fifo.sv
module csvp_out_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  csvp_pkg::push_t push,
    output logic            room,
    csvp_out_if.source      result
);

    csvp_pkg::result_t mem_reg [csvp_pkg::FIFO_DEPTH];

    logic [csvp_pkg::FIFO_PTR_W-1:0] head_reg, head_next;
    logic [csvp_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic [csvp_pkg::FIFO_PTR_W-1:0] tail0, tail1;
    logic                            pop;
    csvp_pkg::result_t               head_item;

    assign room  = (count_reg <= csvp_pkg::FIFO_CNT_W'(csvp_pkg::FIFO_DEPTH - 2));
    assign pop   = result.valid && result.ready;
    assign tail0 = head_reg + count_reg[csvp_pkg::FIFO_PTR_W-1:0];
    assign tail1 = tail0 + csvp_pkg::FIFO_PTR_W'(1);

    always_comb
    begin
        head_next  = pop ? head_reg + csvp_pkg::FIFO_PTR_W'(1) : head_reg;
        count_next = count_reg + csvp_pkg::FIFO_CNT_W'(push.count)
                   - csvp_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[tail0] <= push.item0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[tail1] <= push.item1;
        end
    end

    assign head_item          = mem_reg[head_reg];
    assign result.valid       = (count_reg != '0);
    assign result.item_kind   = head_item.item_kind;
    assign result.cell_row    = head_item.cell_row;
    assign result.cell_column = head_item.cell_column;
    assign result.cell_value  = head_item.cell_value;
    assign result.rows_found  = head_item.rows_found;
    assign result.cols_found  = head_item.cols_found;
    assign result.parse_error = head_item.parse_error;
    assign result.end_of_run  = head_item.end_of_run;

endmodule

FILE: hdl/csv_integer_grid_parser.sv
// Channel  Role    Carries
// text     sink    text_byte, final_byte
// result   source  item_kind, cell_row, cell_column, cell_value, rows_found,
//                  cols_found, parse_error, end_of_run
//
// One text byte is accepted per cycle while text.ready is high; its cell and summary
// requests appear on the result channel from the next cycle on, one per ready cycle.
// The rate is set by the four-entry result queue: text.ready drops while the queue
// holds more than two requests, since a final byte can add two at once.
// Reset clears the parse state and empties the queue; no clearing pass is needed.
module csv_integer_grid_parser #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    csvp_in_if.sink    text,
    csvp_out_if.source result
);

    csvp_pkg::push_t push;
    logic            room;

    csvp_parser #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text),
        .room  (room),
        .push  (push)
    );

    csvp_out_fifo u_out_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .result (result)
    );

endmodule

FILE: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS_CAP    = 64;
    localparam int COLS_CAP    = 64;
    localparam int STALL_LIMIT = 3000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    csvp_in_if  text_ch ();
    csvp_out_if result_ch ();

    csv_integer_grid_parser #(
        .MAX_ROWS(ROWS_CAP),
        .MAX_COLS(COLS_CAP)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .text(text_ch),
        .result(result_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Parser state as the block should hold it.
    csvp_pkg::phase_t ph;
    logic [31:0] magnitude;
    logic        negative;
    logic        seen_digit;
    logic        width_fixed;
    logic        row_counted;
    logic        halted;
    logic        error_seen;
    int          cur_row;
    int          cur_col;
    int          row_count;
    int          col_count;

    csvp_pkg::result_t parsed_items[$];
    logic [7:0]        csv_text[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_len = 0;
    int held_cycles = 0;
    int quiet_cycles = 0;
    int bytes_fed = 0;
    int fail_count = 0;

    function automatic void clear_parser();
        ph = csvp_pkg::PH_START;
        magnitude = '0;
        negative = 1'b0;
        seen_digit = 1'b0;
        width_fixed = 1'b0;
        row_counted = 1'b0;
        halted = 1'b0;
        error_seen = 1'b0;
        cur_row = 0;
        cur_col = 0;
        row_count = 0;
        col_count = 0;
    endfunction

    function automatic csvp_pkg::result_t cell_write();
        csvp_pkg::result_t r;
        r = '0;
        r.item_kind = csvp_pkg::KIND_CELL;
        r.cell_row = 6'(cur_row);
        r.cell_column = 6'(cur_col);
        if (negative)
        begin
            r.cell_value = 32'd0 - magnitude;
        end
        else
        begin
            r.cell_value = (magnitude > csvp_pkg::POS_MAX) ? csvp_pkg::POS_MAX : magnitude;
        end
        return r;
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic fin);
        csvp_pkg::result_t outs[$];
        csvp_pkg::result_t r;
        logic [63:0]       grown;
        logic              digit;
        logic              busy;
        digit = (b >= csvp_pkg::CH_ZERO) && (b <= csvp_pkg::CH_NINE);
        busy = !halted;
        if (busy && ph == csvp_pkg::PH_START)
        begin
            if (cur_row >= ROWS_CAP)
            begin
                busy = 1'b0;
            end
            else
            begin
                if (!width_fixed)
                    col_count++;
                if (!row_counted)
                begin
                    row_count++;
                    row_counted = 1'b1;
                end
                ph = csvp_pkg::PH_SPACE;
            end
        end
        if (busy && ph == csvp_pkg::PH_SPACE)
        begin
            if (b == csvp_pkg::CH_SPACE || b == csvp_pkg::CH_TAB || b == csvp_pkg::CH_CR
                || b == csvp_pkg::CH_VT || b == csvp_pkg::CH_FF)
            begin
                busy = 1'b0;
            end
            else if (b == csvp_pkg::CH_PLUS || b == csvp_pkg::CH_MINUS)
            begin
                negative = (b == csvp_pkg::CH_MINUS);
                ph = csvp_pkg::PH_NUMBER;
                busy = 1'b0;
            end
            else if (digit)
            begin
                ph = csvp_pkg::PH_NUMBER;
            end
            else
            begin
                error_seen = 1'b1;
                halted = 1'b1;
                busy = 1'b0;
            end
        end
        if (busy && ph == csvp_pkg::PH_NUMBER)
        begin
            if (digit)
            begin
                grown = 64'(magnitude) * 64'd10 + 64'(b - csvp_pkg::CH_ZERO);
                magnitude = (grown > 64'(csvp_pkg::MAG_LIMIT)) ? csvp_pkg::MAG_LIMIT
                                                                : grown[31:0];
                seen_digit = 1'b1;
                busy = 1'b0;
            end
            else if (!seen_digit)
            begin
                error_seen = 1'b1;
                halted = 1'b1;
                busy = 1'b0;
            end
            else
            begin
                outs.push_back(cell_write());
                ph = csvp_pkg::PH_SKIP;
            end
        end
        if (busy && (b == csvp_pkg::CH_COMMA || b == csvp_pkg::CH_NEWLINE
                     || b == csvp_pkg::CH_NUL))
        begin
            if (b == csvp_pkg::CH_NEWLINE)
            begin
                cur_col = 0;
                cur_row++;
                width_fixed = 1'b1;
                row_counted = 1'b0;
            end
            else
            begin
                cur_col++;
                if (cur_col >= COLS_CAP)
                begin
                    cur_col = 0;
                    cur_row++;
                end
            end
            ph = csvp_pkg::PH_START;
            magnitude = '0;
            negative = 1'b0;
            seen_digit = 1'b0;
        end
        if (fin)
        begin
            if (!halted)
            begin
                if (ph == csvp_pkg::PH_NUMBER && seen_digit)
                begin
                    outs.push_back(cell_write());
                end
                else if (ph == csvp_pkg::PH_SPACE || ph == csvp_pkg::PH_NUMBER)
                begin
                    error_seen = 1'b1;
                    halted = 1'b1;
                end
            end
            r = '0;
            r.item_kind = csvp_pkg::KIND_SUMMARY;
            r.rows_found = 7'(row_count);
            r.cols_found = 13'(col_count);
            r.parse_error = error_seen;
            outs.push_back(r);
            clear_parser();
        end
        foreach (outs[i])
        begin
            r = outs[i];
            r.end_of_run = (i == outs.size() - 1);
            parsed_items.push_back(r);
        end
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        csvp_pkg::result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (parsed_items.size() == 0)
            begin
                $display("%0t: unexpected request, kind %0d row %0d column %0d value %0d",
                         $time, result_ch.item_kind, result_ch.cell_row,
                         result_ch.cell_column, result_ch.cell_value);
                fail_count++;
            end
            else
            begin
                want = parsed_items.pop_front();
                check_field("item_kind", want.item_kind, result_ch.item_kind);
                check_field("cell_row", want.cell_row, result_ch.cell_row);
                check_field("cell_column", want.cell_column, result_ch.cell_column);
                check_field("cell_value", $signed(want.cell_value),
                            $signed(result_ch.cell_value));
                check_field("rows_found", want.rows_found, result_ch.rows_found);
                check_field("cols_found", want.cols_found, result_ch.cols_found);
                check_field("parse_error", want.parse_error, result_ch.parse_error);
                check_field("end_of_run", want.end_of_run, result_ch.end_of_run);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else if (held_cycles < hold_len)
        begin
            result_ch.ready <= 1'b0;
            held_cycles <= held_cycles + 1;
        end
        else
        begin
            result_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL csv_integer_grid_parser");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic feed_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            text_ch.valid <= 1'b0;
            @(posedge clk);
        end
        text_ch.valid <= 1'b1;
        text_ch.text_byte <= b;
        text_ch.final_byte <= fin;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        parse_byte(b, fin);
        bytes_fed++;
    endtask

    // The last byte of the buffer carries the final mark.
    task automatic feed_buffer();
        for (int i = 0; i < csv_text.size(); i++)
            feed_byte(csv_text[i], i == csv_text.size() - 1);
        csv_text.delete();
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            csv_text.push_back(s[i]);
    endfunction

    function automatic void add_blank();
        case ($urandom_range(4, 0))
            0: csv_text.push_back(csvp_pkg::CH_SPACE);
            1: csv_text.push_back(csvp_pkg::CH_TAB);
            2: csv_text.push_back(csvp_pkg::CH_CR);
            3: csv_text.push_back(csvp_pkg::CH_VT);
            default: csv_text.push_back(csvp_pkg::CH_FF);
        endcase
    endfunction

    function automatic void add_noise(input int n);
        repeat (n)
        begin
            case ($urandom_range(7, 0))
                0, 1, 2: csv_text.push_back(8'($urandom_range(255, 0)));
                3: csv_text.push_back(csvp_pkg::CH_ZERO + 8'($urandom_range(9, 0)));
                4: csv_text.push_back(csvp_pkg::CH_COMMA);
                5: csv_text.push_back(csvp_pkg::CH_NEWLINE);
                6: csv_text.push_back(csvp_pkg::CH_NUL);
                default: add_blank();
            endcase
        end
    endfunction

    function automatic void add_number();
        int n;
        n = ($urandom_range(3, 0) == 0) ? $urandom_range(3, 1) : 0;
        repeat (n)
            add_blank();
        case ($urandom_range(3, 0))
            0: csv_text.push_back(csvp_pkg::CH_PLUS);
            1: csv_text.push_back(csvp_pkg::CH_MINUS);
            default: ;
        endcase
        n = ($urandom_range(7, 0) == 0) ? $urandom_range(14, 9) : $urandom_range(3, 1);
        repeat (n)
            csv_text.push_back(csvp_pkg::CH_ZERO + 8'($urandom_range(9, 0)));
        if ($urandom_range(9, 0) == 0)
            csv_text.push_back($urandom_range(1, 0) ? csvp_pkg::CH_SPACE
                                                    : 8'($urandom_range(255, 128)));
    endfunction

    function automatic void add_grid(input int rows, input int cols);
        int ncols;
        for (int r = 0; r < rows; r++)
        begin
            ncols = ($urandom_range(4, 0) == 0) ? $urandom_range(cols + 2, 1) : cols;
            for (int c = 0; c < ncols; c++)
            begin
                if ($urandom_range(19, 0) == 0)
                    add_noise(1);
                else
                    add_number();
                if (c < ncols - 1)
                    csv_text.push_back(($urandom_range(9, 0) == 0) ? csvp_pkg::CH_NUL
                                                                   : csvp_pkg::CH_COMMA);
            end
            if (r < rows - 1 || $urandom_range(1, 0) == 1)
                csv_text.push_back(csvp_pkg::CH_NEWLINE);
        end
    endfunction

    task automatic test_blanks_and_signs();
        csv_text.push_back(csvp_pkg::CH_SPACE);
        csv_text.push_back(csvp_pkg::CH_TAB);
        csv_text.push_back(csvp_pkg::CH_CR);
        csv_text.push_back(csvp_pkg::CH_VT);
        csv_text.push_back(csvp_pkg::CH_FF);
        add_text("-5,+3x");
        csv_text.push_back(csvp_pkg::CH_NEWLINE);
        add_text("7");
        feed_buffer();
    endtask

    task automatic test_missing_digits();
        add_text("+,");
        feed_buffer();
        add_text("a");
        feed_buffer();
        add_text(",");
        feed_buffer();
        csv_text.push_back(csvp_pkg::CH_SPACE);
        feed_buffer();
        add_text("x9");
        feed_buffer();
    endtask

    task automatic test_separators();
        add_text("1");
        csv_text.push_back(8'hFF);
        csv_text.push_back(csvp_pkg::CH_NUL);
        add_text("2");
        csv_text.push_back(csvp_pkg::CH_NEWLINE);
        add_text("3,4,5");
        feed_buffer();
    endtask

    task automatic test_saturation();
        add_text("-2147483648,2147483648");
        feed_buffer();
    endtask

    task automatic test_row_capacity();
        repeat (ROWS_CAP + 2)
        begin
            csv_text.push_back(csvp_pkg::CH_ZERO + 8'($urandom_range(9, 0)));
            csv_text.push_back(csvp_pkg::CH_NEWLINE);
        end
        add_text("7");
        feed_buffer();
    endtask

    task automatic test_column_wrap();
        repeat (COLS_CAP + 2)
        begin
            csv_text.push_back(csvp_pkg::CH_ZERO + 8'($urandom_range(9, 0)));
            csv_text.push_back(csvp_pkg::CH_COMMA);
        end
        add_text("8");
        feed_buffer();
    endtask

    // The receiver stops long enough for the result queue to fill and stall the text side.
    task automatic test_output_backpressure();
        hold_len = held_cycles + 300;
        add_grid(3, 6);
        feed_buffer();
    endtask

    task automatic test_random_buffers(input int n_bytes);
        int stop_at;
        int pick;
        stop_at = bytes_fed + n_bytes;
        while (bytes_fed < stop_at)
        begin
            pick = $urandom_range(39, 0);
            if (pick < 28)
                add_grid($urandom_range(4, 1), $urandom_range(5, 1));
            else if (pick == 28)
                add_grid($urandom_range(68, 60), 1);
            else if (pick == 29)
                add_grid(1, $urandom_range(70, 60));
            else
                add_noise($urandom_range(12, 1));
            feed_buffer();
        end
    endtask

    initial
    begin
        clear_parser();
        text_ch.valid <= 1'b0;
        text_ch.text_byte <= '0;
        text_ch.final_byte <= 1'b0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle(34, 65);
        test_blanks_and_signs();
        test_missing_digits();
        test_separators();
        test_saturation();
        test_row_capacity();
        test_column_wrap();
        test_random_buffers(350);

        set_idle(65, 34);
        test_output_backpressure();
        test_random_buffers(350);

        set_idle(0, 0);
        test_random_buffers(350);

        text_ch.valid <= 1'b0;
        while (parsed_items.size() != 0)
            @(posedge clk);
        repeat (16)
            @(posedge clk);
        if (fail_count == 0)
            $display("PASS csv_integer_grid_parser");
        else
            $display("FAIL csv_integer_grid_parser");
        $finish;
    end

endmodule
